@@ design/binary_lifting_ancestor_table_core_assert.svh @@
// Assertion macros for the ancestor table core
`ifndef BINARY_LIFTING_ANCESTOR_TABLE_CORE_ASSERT_SVH
`define BINARY_LIFTING_ANCESTOR_TABLE_CORE_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define BLAT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blat check failed");
// next-cycle implication, sampled on clk, off during reset
`define BLAT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blat check failed");
`endif

@@ design/blat_pkg.sv @@
// Shared command and status codes for the ancestor table core
package blat_pkg;
	typedef enum logic [1:0] {
		CMD_INSERT    = 2'd0,
		CMD_LEVEL_ANC = 2'd1,
		CMD_LCA       = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DEPTH = 2'd1,
		ST_UNSET = 2'd2
	} status_t;

	localparam logic [10:0] PARENT_ROOT = 11'h7FF;
	localparam int ROOT_LEVEL = 1;
endpackage

@@ design/blat_ram.sv @@
// Simple dual-port synchronous RAM with registered read data
module blat_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/blat_ctrl.sv @@
// Command sequencer: insert, level ancestor and LCA over the level and jump stores
`include "binary_lifting_ancestor_table_core_assert.svh"
module blat_ctrl #(
	parameter int MAX_VERTICES = 1024,
	parameter int JUMP_LEVELS  = 11
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  blat_pkg::cmd_t                             command,
	input  logic [9:0]                                 vertex,
	input  logic signed [10:0]                         parent_vertex,
	input  logic [9:0]                                 steps_up,
	input  logic [9:0]                                 other_vertex,
	output logic                                       busy,
	output logic                                       done,
	output logic [9:0]                                 result_vertex,
	output logic [10:0]                                result_level,
	output blat_pkg::status_t                          status,
	output logic                                       lvl_we,
	output logic [$clog2(MAX_VERTICES)-1:0]            lvl_waddr,
	output logic [$clog2(MAX_VERTICES+1)-1:0]          lvl_wdata,
	output logic [$clog2(MAX_VERTICES)-1:0]            lvl_raddr,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]          lvl_rdata,
	output logic                                       jmp_we,
	output logic [$clog2(MAX_VERTICES*JUMP_LEVELS)-1:0] jmp_waddr,
	output logic [$clog2(MAX_VERTICES+1)-1:0]          jmp_wdata,
	output logic [$clog2(MAX_VERTICES*JUMP_LEVELS)-1:0] jmp_raddr,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]          jmp_rdata
);
	import blat_pkg::*;

	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int VW  = $clog2(MAX_VERTICES + 1);
	localparam int LW  = $clog2(MAX_VERTICES + 1);
	localparam int JAW = $clog2(MAX_VERTICES * JUMP_LEVELS);
	localparam int IW  = $clog2(JUMP_LEVELS);
	localparam int IW1 = $clog2(JUMP_LEVELS + 1);
	localparam logic [VW-1:0] NONE = VW'(MAX_VERTICES);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_INS_P, S_INS_LOOP, S_INS_MID, S_INS_WR,
		S_LA_L, S_LA_END, S_LC_LX, S_LC_LY, S_LC_CMP, S_CL_STEP, S_CL_RES,
		S_LIFT, S_LF_X, S_LF_Y, S_FN_X, S_FN_Y, S_J_A, S_J_B, S_J_C
	} state_t;

	state_t          state_q, jret_q, cret_q;
	logic [AW-1:0]   clr_q;
	logic [VW-1:0]   x_q, y_q, p_q, jx_q, jsrc_q, jres_q;
	logic [LW-1:0]   lx_q, ly_q, k_q, ljx_q, jlev_q, jlx_q;
	logic [9:0]      kin_q;
	logic [IW1-1:0]  i_q;
	logic [IW-1:0]   jidx_q;
	logic            moved_q;
	logic            done_q;
	logic [9:0]      rv_q;
	logic [10:0]     rl_q;
	status_t         st_q;
	logic            insert_ok;
	logic            mv;
	logic [IW-1:0]   sel;

	function automatic logic [JAW-1:0] jaddr(input logic [VW-1:0] v, input logic [31:0] idx);
		return JAW'(32'(v) * JUMP_LEVELS + idx);
	endfunction

	function automatic logic [IW-1:0] step_sel(input logic [LW-1:0] k);
		int msb;
		msb = 0;
		for (int b = 0; b < LW; b++) begin
			if (k[b]) msb = b;
		end
		if (msb > JUMP_LEVELS - 1) msb = JUMP_LEVELS - 1;
		return IW'(msb);
	endfunction

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign result_vertex = rv_q;
	assign result_level  = rl_q;
	assign status        = st_q;

	assign insert_ok = (lvl_rdata != '0) && (32'(lvl_rdata) < MAX_VERTICES);
	assign sel       = step_sel(k_q);
	assign mv        = (jx_q != NONE) && (jres_q != NONE) && (jx_q != jres_q) &&
		(ljx_q == jlev_q);

	always_comb begin
		lvl_we    = 1'b0;
		lvl_waddr = x_q[AW-1:0];
		lvl_wdata = '0;
		lvl_raddr = jsrc_q[AW-1:0];
		jmp_we    = 1'b0;
		jmp_waddr = jaddr(x_q, 32'(i_q));
		jmp_wdata = jres_q;
		jmp_raddr = jaddr(jsrc_q, 32'(jidx_q));
		unique case (state_q)
			S_CLEAR: begin
				lvl_we    = 1'b1;
				lvl_waddr = clr_q;
			end
			S_IDLE: begin
				lvl_raddr = (command == CMD_INSERT) ? AW'(parent_vertex[9:0]) : AW'(vertex);
				if (start && command == CMD_INSERT && 32'(vertex) < MAX_VERTICES &&
					parent_vertex == PARENT_ROOT) begin
					lvl_we    = 1'b1;
					lvl_waddr = AW'(vertex);
					lvl_wdata = LW'(ROOT_LEVEL);
					jmp_we    = 1'b1;
					jmp_waddr = jaddr(VW'(vertex), 32'd0);
					jmp_wdata = NONE;
				end
			end
			S_INS_P: begin
				if (insert_ok) begin
					lvl_we    = 1'b1;
					lvl_wdata = lvl_rdata + LW'(1);
					jmp_we    = 1'b1;
					jmp_waddr = jaddr(x_q, 32'd0);
					jmp_wdata = p_q;
				end
			end
			S_LC_LX: lvl_raddr = y_q[AW-1:0];
			S_J_B:   lvl_raddr = jmp_rdata[AW-1:0];
			S_INS_WR: jmp_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == MAX_VERTICES - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					x_q   <= VW'(vertex);
					y_q   <= VW'(other_vertex);
					p_q   <= VW'(parent_vertex[9:0]);
					kin_q <= steps_up;
					if (start) begin
						unique case (command)
							CMD_INSERT: begin
								rv_q <= vertex;
								if (32'(vertex) >= MAX_VERTICES) begin
									done_q <= 1'b1; rl_q <= '0; st_q <= ST_UNSET;
								end else if (parent_vertex == PARENT_ROOT) begin
									done_q <= 1'b1; rl_q <= 11'(ROOT_LEVEL); st_q <= ST_OK;
								end else if (parent_vertex[10] ||
									32'(parent_vertex[9:0]) >= MAX_VERTICES) begin
									done_q <= 1'b1; rl_q <= '0; st_q <= ST_UNSET;
								end else begin
									state_q <= S_INS_P;
								end
							end
							CMD_LEVEL_ANC: begin
								if (32'(vertex) >= MAX_VERTICES) begin
									done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_UNSET;
								end else begin
									state_q <= S_LA_L;
								end
							end
							CMD_LCA: begin
								if (32'(vertex) >= MAX_VERTICES ||
									32'(other_vertex) >= MAX_VERTICES) begin
									done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_UNSET;
								end else begin
									state_q <= S_LC_LX;
								end
							end
							default: begin
								done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_UNSET;
							end
						endcase
					end
				end
				S_INS_P: begin
					if (lvl_rdata == '0) begin
						done_q <= 1'b1; rl_q <= '0; st_q <= ST_UNSET; state_q <= S_IDLE;
					end else if (!insert_ok) begin
						done_q <= 1'b1; rl_q <= '0; st_q <= ST_DEPTH; state_q <= S_IDLE;
					end else begin
						lx_q    <= lvl_rdata + LW'(1);
						i_q     <= IW1'(1);
						state_q <= S_INS_LOOP;
					end
				end
				S_INS_LOOP: begin
					if (32'(i_q) < JUMP_LEVELS && (32'(1) << i_q) < 32'(lx_q)) begin
						jsrc_q  <= x_q;
						jidx_q  <= IW'(i_q - IW1'(1));
						jret_q  <= S_INS_MID;
						state_q <= S_J_A;
					end else begin
						done_q  <= 1'b1;
						rv_q    <= 10'(x_q);
						rl_q    <= 11'(lx_q);
						st_q    <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				S_INS_MID: begin
					if (jres_q == NONE) begin
						state_q <= S_INS_WR;
					end else begin
						jsrc_q  <= jres_q;
						jidx_q  <= IW'(i_q - IW1'(1));
						jret_q  <= S_INS_WR;
						state_q <= S_J_A;
					end
				end
				S_INS_WR: begin
					i_q     <= i_q + IW1'(1);
					state_q <= S_INS_LOOP;
				end
				S_LA_L: begin
					if (lvl_rdata == '0) begin
						done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_UNSET;
						state_q <= S_IDLE;
					end else if (32'(kin_q) >= 32'(lvl_rdata)) begin
						done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_DEPTH;
						state_q <= S_IDLE;
					end else begin
						lx_q    <= lvl_rdata;
						k_q     <= LW'(kin_q);
						cret_q  <= S_LA_END;
						state_q <= S_CL_STEP;
					end
				end
				S_LA_END: begin
					done_q  <= 1'b1;
					rv_q    <= 10'(x_q);
					rl_q    <= 11'(lx_q);
					st_q    <= ST_OK;
					state_q <= S_IDLE;
				end
				S_LC_LX: begin
					lx_q    <= lvl_rdata;
					state_q <= S_LC_LY;
				end
				S_LC_LY: begin
					if (lx_q == '0 || lvl_rdata == '0) begin
						done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_UNSET;
						state_q <= S_IDLE;
					end else begin
						if (lvl_rdata > lx_q) begin
							x_q  <= y_q;
							y_q  <= x_q;
							lx_q <= lvl_rdata;
							ly_q <= lx_q;
							k_q  <= lvl_rdata - lx_q;
						end else begin
							ly_q <= lvl_rdata;
							k_q  <= lx_q - lvl_rdata;
						end
						cret_q  <= S_LC_CMP;
						state_q <= S_CL_STEP;
					end
				end
				S_CL_STEP: begin
					if (k_q == '0) begin
						state_q <= cret_q;
					end else begin
						i_q     <= IW1'(sel);
						jsrc_q  <= x_q;
						jidx_q  <= sel;
						jret_q  <= S_CL_RES;
						state_q <= S_J_A;
					end
				end
				S_CL_RES: begin
					if (jres_q == NONE) begin
						done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_DEPTH;
						state_q <= S_IDLE;
					end else begin
						x_q     <= jres_q;
						lx_q    <= jlev_q;
						k_q     <= k_q - LW'(32'(1) << i_q);
						state_q <= S_CL_STEP;
					end
				end
				S_LC_CMP: begin
					if (lx_q != ly_q) begin
						done_q <= 1'b1; rv_q <= '0; rl_q <= '0; st_q <= ST_DEPTH;
						state_q <= S_IDLE;
					end else if (x_q == y_q) begin
						done_q <= 1'b1; rv_q <= 10'(x_q); rl_q <= 11'(lx_q); st_q <= ST_OK;
						state_q <= S_IDLE;
					end else begin
						i_q     <= IW1'(JUMP_LEVELS - 1);
						moved_q <= 1'b0;
						state_q <= S_LIFT;
					end
				end
				S_LIFT: begin
					jsrc_q  <= x_q;
					jidx_q  <= IW'(i_q);
					jret_q  <= S_LF_X;
					state_q <= S_J_A;
				end
				S_LF_X: begin
					jx_q    <= jres_q;
					ljx_q   <= jlev_q;
					jsrc_q  <= y_q;
					jret_q  <= S_LF_Y;
					state_q <= S_J_A;
				end
				S_LF_Y: begin
					if (mv) begin
						x_q  <= jx_q;
						lx_q <= ljx_q;
						y_q  <= jres_q;
						ly_q <= jlev_q;
					end
					if (i_q == '0) begin
						if (moved_q || mv) begin
							i_q     <= IW1'(JUMP_LEVELS - 1);
							moved_q <= 1'b0;
							state_q <= S_LIFT;
						end else begin
							jsrc_q  <= x_q;
							jidx_q  <= '0;
							jret_q  <= S_FN_X;
							state_q <= S_J_A;
						end
					end else begin
						i_q     <= i_q - IW1'(1);
						moved_q <= moved_q | mv;
						state_q <= S_LIFT;
					end
				end
				S_FN_X: begin
					jx_q    <= jres_q;
					jsrc_q  <= y_q;
					jidx_q  <= '0;
					jret_q  <= S_FN_Y;
					state_q <= S_J_A;
				end
				S_FN_Y: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (jx_q == NONE || jx_q != jres_q) begin
						rv_q <= '0; rl_q <= '0; st_q <= ST_DEPTH;
					end else begin
						rv_q <= 10'(jx_q); rl_q <= 11'(jlev_q); st_q <= ST_OK;
					end
				end
				S_J_A: state_q <= S_J_B;
				S_J_B: begin
					if ((32'(1) << jidx_q) >= 32'(lvl_rdata) ||
						32'(jmp_rdata) >= MAX_VERTICES) begin
						jres_q  <= NONE;
						jlev_q  <= '0;
						state_q <= jret_q;
					end else begin
						jlx_q   <= lvl_rdata;
						jres_q  <= jmp_rdata;
						state_q <= S_J_C;
					end
				end
				S_J_C: begin
					if (lvl_rdata == '0 || lvl_rdata >= jlx_q) begin
						jres_q <= NONE;
						jlev_q <= '0;
					end else begin
						jlev_q <= lvl_rdata;
					end
					state_q <= jret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BLAT_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
	`BLAT_ASSERT_IMP(a_done_idle, done, !busy)
	`BLAT_ASSERT_IMP(a_clear_quiet, state_q == S_CLEAR, lvl_we && !jmp_we && !done)
	`BLAT_ASSERT_IMP(a_jump_write, jmp_we,
		state_q == S_IDLE || state_q == S_INS_P || state_q == S_INS_WR)
endmodule

@@ design/binary_lifting_ancestor_table_core.sv @@
// Top level of the binary lifting ancestor table core
// Usage:
//   Drive command, vertex, parent_vertex, steps_up and other_vertex with start high;
//   the item is taken at a clock edge where start is high and busy is low.
//   One result per item appears on result_vertex, result_level and status for a
//   single cycle with done high; the receiver cannot stall and must take it then.
// Sequencing (busy is low in the cycle with done high, so the next item can be
// taken at its closing edge; one item at a time):
//   insert: a root or a negative parent is answered from idle; otherwise the parent
//   level is read (an unset or too deep parent is rejected), then each jump entry
//   is filled by one or two jump lookups (one when it has no midpoint).
//   level ancestor: rejected after its level is read, else one lookup per jump taken.
//   LCA: rejected after both levels are read; otherwise leveling jumps, then
//   lifting passes and a parent check when the leveled vertices still differ.
//   A jump lookup reads source level and jump entry together, then the target level.
// Reset: arst_n clears control state, then a sweep over all MAX_VERTICES entries zeroes
//   the level store with busy high; the jump store needs no clearing.
module binary_lifting_ancestor_table_core #(
	parameter int MAX_VERTICES = 1024,
	parameter int JUMP_LEVELS  = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  blat_pkg::cmd_t           command,
	input  logic [9:0]               vertex,
	input  logic signed [10:0]       parent_vertex,
	input  logic [9:0]               steps_up,
	input  logic [9:0]               other_vertex,
	output logic                     done,
	output logic [9:0]               result_vertex,
	output logic [10:0]              result_level,
	output blat_pkg::status_t        status
);
	import blat_pkg::*;

	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int VW  = $clog2(MAX_VERTICES + 1);
	localparam int JAW = $clog2(MAX_VERTICES * JUMP_LEVELS);

	logic           lvl_we, jmp_we;
	logic [AW-1:0]  lvl_waddr, lvl_raddr;
	logic [VW-1:0]  lvl_wdata, lvl_rdata, jmp_wdata, jmp_rdata;
	logic [JAW-1:0] jmp_waddr, jmp_raddr;

	blat_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_level (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (lvl_wdata),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	blat_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES * JUMP_LEVELS)) u_jump (
		.clk   (clk),
		.we    (jmp_we),
		.waddr (jmp_waddr),
		.wdata (jmp_wdata),
		.raddr (jmp_raddr),
		.rdata (jmp_rdata)
	);

	blat_ctrl #(.MAX_VERTICES(MAX_VERTICES), .JUMP_LEVELS(JUMP_LEVELS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.command       (command),
		.vertex        (vertex),
		.parent_vertex (parent_vertex),
		.steps_up      (steps_up),
		.other_vertex  (other_vertex),
		.busy          (busy),
		.done          (done),
		.result_vertex (result_vertex),
		.result_level  (result_level),
		.status        (status),
		.lvl_we        (lvl_we),
		.lvl_waddr     (lvl_waddr),
		.lvl_wdata     (lvl_wdata),
		.lvl_raddr     (lvl_raddr),
		.lvl_rdata     (lvl_rdata),
		.jmp_we        (jmp_we),
		.jmp_waddr     (jmp_waddr),
		.jmp_wdata     (jmp_wdata),
		.jmp_raddr     (jmp_raddr),
		.jmp_rdata     (jmp_rdata)
	);
endmodule

@@ dv/binary_lifting_ancestor_table_core_checker.sv @@
// Checker for the ancestor table core: predicts each result and compares it
`timescale 1ns / 1ps
module binary_lifting_ancestor_table_core_checker #(
	parameter int MAX_VERTICES = 1024,
	parameter int JUMP_LEVELS  = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  blat_pkg::cmd_t     command,
	input  logic [9:0]         vertex,
	input  logic signed [10:0] parent_vertex,
	input  logic [9:0]         steps_up,
	input  logic [9:0]         other_vertex,
	input  logic               done,
	input  logic [9:0]         result_vertex,
	input  logic [10:0]        result_level,
	input  blat_pkg::status_t  status,
	output int                 fail_count,
	output int                 pending
);
	import blat_pkg::*;

	localparam int NONE = MAX_VERTICES;

	typedef struct packed {
		logic [9:0]  vtx;
		logic [10:0] lvl;
		status_t     st;
	} anc_result_t;

	int          depth_of [MAX_VERTICES];
	int          jump_row [MAX_VERTICES][JUMP_LEVELS];
	anc_result_t anc_expected [$];

	function automatic int follow_jump(int x, int i);
		int t;
		if (x >= NONE || i >= JUMP_LEVELS) return NONE;
		if ((1 << i) >= depth_of[x]) return NONE;
		t = jump_row[x][i];
		if (t >= NONE || depth_of[t] == 0 || depth_of[t] >= depth_of[x]) return NONE;
		return t;
	endfunction

	function automatic int climb_levels(int x, int k);
		int i;
		while (k != 0) begin
			i = 0;
			while (i + 1 < JUMP_LEVELS && (1 << (i + 1)) <= k) i++;
			x = follow_jump(x, i);
			if (x == NONE) return NONE;
			k -= 1 << i;
		end
		return x;
	endfunction

	function automatic anc_result_t predict_ancestor(cmd_t c, int x, logic [10:0] p, int k,
			int y);
		anc_result_t r;
		int lv, mid, lx, ly, jx, jy, px, py;
		bit moved;
		r = '{vtx: 0, lvl: 0, st: ST_OK};
		case (c)
			CMD_INSERT: begin
				r.vtx = 10'(x);
				if (p == PARENT_ROOT) begin
					depth_of[x] = ROOT_LEVEL;
					jump_row[x][0] = NONE;
					r.lvl = 11'(ROOT_LEVEL);
				end else if (p[10] || depth_of[p] == 0) begin
					r.st = ST_UNSET;
				end else if (depth_of[p] >= MAX_VERTICES) begin
					r.st = ST_DEPTH;
				end else begin
					lv = depth_of[p] + 1;
					depth_of[x] = lv;
					jump_row[x][0] = int'(p);
					for (int i = 1; i < JUMP_LEVELS && (1 << i) < lv; i++) begin
						mid = follow_jump(x, i - 1);
						jump_row[x][i] = (mid == NONE) ? NONE : follow_jump(mid, i - 1);
					end
					r.lvl = 11'(lv);
				end
			end
			CMD_LEVEL_ANC: begin
				if (depth_of[x] == 0) r.st = ST_UNSET;
				else if (k >= depth_of[x]) r.st = ST_DEPTH;
				else begin
					mid = climb_levels(x, k);
					if (mid == NONE) r.st = ST_DEPTH;
					else begin
						r.vtx = 10'(mid);
						r.lvl = 11'(depth_of[mid]);
					end
				end
			end
			CMD_LCA: begin
				if (depth_of[x] == 0 || depth_of[y] == 0) r.st = ST_UNSET;
				else begin
					lx = depth_of[x];
					ly = depth_of[y];
					if (lx > ly) x = climb_levels(x, lx - ly);
					else if (ly > lx) y = climb_levels(y, ly - lx);
					if (x == NONE || y == NONE || depth_of[x] != depth_of[y]) r.st = ST_DEPTH;
					else if (x != y) begin
						moved = 1;
						while (moved) begin
							moved = 0;
							for (int i = JUMP_LEVELS - 1; i >= 0; i--) begin
								jx = follow_jump(x, i);
								jy = follow_jump(y, i);
								if (jx != NONE && jy != NONE && jx != jy &&
										depth_of[jx] == depth_of[jy]) begin
									x = jx;
									y = jy;
									moved = 1;
								end
							end
						end
						px = follow_jump(x, 0);
						py = follow_jump(y, 0);
						if (px == NONE || px != py) r.st = ST_DEPTH;
						else x = px;
					end
					if (r.st == ST_OK) begin
						r.vtx = 10'(x);
						r.lvl = 11'(depth_of[x]);
					end
				end
			end
			default: r.st = ST_UNSET;
		endcase
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		foreach (depth_of[v]) depth_of[v] = 0;
		foreach (jump_row[v, i]) jump_row[v][i] = NONE;
	end

	always @(posedge clk) begin
		anc_result_t want;
		if (arst_n) begin
			if (done) begin
				if (anc_expected.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: vertex %0d level %0d status %0d",
							result_vertex, result_level, status);
					fail_count++;
				end else begin
					want = anc_expected.pop_front();
					if (want.vtx !== result_vertex || want.lvl !== result_level ||
							want.st !== status) begin
						if (fail_count < 10)
							$display("mismatch: expected v %0d l %0d s %0d, got v %0d l %0d s %0d",
								want.vtx, want.lvl, want.st, result_vertex, result_level, status);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				anc_expected.insert(anc_expected.size(), predict_ancestor(command, vertex,
					parent_vertex, steps_up, other_vertex));
			pending = anc_expected.size();
		end
	end
endmodule

@@ dv/binary_lifting_ancestor_table_core_tb.sv @@
// Testbench top for the ancestor table core: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module binary_lifting_ancestor_table_core_tb;
	import blat_pkg::*;

	localparam int NV = 1024;
	localparam int STALL_LIMIT = 500000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cmd_t              command;
	logic [9:0]        vertex;
	logic signed [10:0] parent_vertex;
	logic [9:0]        steps_up;
	logic [9:0]        other_vertex;
	logic              done;
	logic [9:0]        result_vertex;
	logic [10:0]       result_level;
	status_t           status;
	int                fail_count;
	int                pending;
	int                stall_cycles = 0;
	bit                placed [NV];
	int                placed_list [$];

	binary_lifting_ancestor_table_core dut (.*);

	binary_lifting_ancestor_table_core_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_item(cmd_t c, int v, int p, int k, int o);
		start <= 1;
		command <= c;
		vertex <= 10'(v);
		parent_vertex <= 11'(p);
		steps_up <= 10'(k);
		other_vertex <= 10'(o);
		if (c == CMD_INSERT && v < NV &&
				(p == 32'(PARENT_ROOT) || (!p[10] && placed[p]))) begin
			if (!placed[v]) placed_list.insert(placed_list.size(), v);
			placed[v] = 1;
		end
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int pick_vertex();
		if (placed_list.size() == 0 || $urandom_range(0, 19) == 0) return $urandom_range(0, NV - 1);
		return placed_list[$urandom_range(0, placed_list.size() - 1)];
	endfunction

	initial begin
		int r, k, p;
		start = 0;
		command = CMD_INSERT;
		vertex = 0;
		parent_vertex = 0;
		steps_up = 0;
		other_vertex = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed: unset vertices, bad parents, a small tree
		send_item(CMD_LEVEL_ANC, 5, 0, 0, 0); idle_gap();
		send_item(CMD_LCA, 5, 0, 0, 6); idle_gap();
		send_item(CMD_INSERT, 5, 11'h7FE, 0, 0); idle_gap();
		send_item(CMD_INSERT, 5, 11'h400, 0, 0); idle_gap();
		send_item(CMD_INSERT, 5, 9, 0, 0); idle_gap();
		send_item(CMD_INSERT, 1023, PARENT_ROOT, 0, 0); idle_gap();
		send_item(CMD_INSERT, 1, 1023, 0, 0); idle_gap();
		send_item(CMD_INSERT, 2, 1, 0, 0); idle_gap();
		send_item(CMD_INSERT, 3, 1, 0, 0); idle_gap();
		send_item(CMD_INSERT, 4, 2, 0, 0); idle_gap();
		send_item(CMD_INSERT, 6, 4, 0, 0); idle_gap();
		send_item(CMD_INSERT, 7, 3, 0, 0); idle_gap();
		send_item(CMD_INSERT, 8, PARENT_ROOT, 0, 0); idle_gap();
		send_item(CMD_LEVEL_ANC, 6, 0, 0, 0); idle_gap();
		send_item(CMD_LEVEL_ANC, 6, 0, 4, 0); idle_gap();
		send_item(CMD_LEVEL_ANC, 6, 0, 5, 0); idle_gap();
		send_item(CMD_LEVEL_ANC, 6, 0, 1023, 0); idle_gap();
		send_item(CMD_LCA, 6, 0, 0, 7); idle_gap();
		send_item(CMD_LCA, 6, 0, 0, 2); idle_gap();
		send_item(CMD_LCA, 6, 0, 0, 6); idle_gap();
		send_item(CMD_LCA, 6, 0, 0, 8); idle_gap();
		send_item(CMD_LCA, 6, 0, 0, 1023); idle_gap();
		send_item(CMD_INSERT, 4, 3, 0, 0); idle_gap();
		send_item(CMD_LCA, 6, 0, 0, 7); idle_gap();

		// full-depth chain over every vertex, then the depth limit
		send_item(CMD_INSERT, 0, PARENT_ROOT, 0, 0); idle_gap();
		for (int v = 1; v < NV; v++) begin
			send_item(CMD_INSERT, v, v - 1, 0, 0);
			idle_gap();
		end
		send_item(CMD_INSERT, 5, 1023, 0, 0); idle_gap();
		send_item(CMD_LEVEL_ANC, 1023, 0, 1023, 0); idle_gap();
		send_item(CMD_LEVEL_ANC, 1023, 0, 1022, 0); idle_gap();
		send_item(CMD_LCA, 1023, 0, 0, 1); idle_gap();

		// random: mostly tree edits under placed parents, plus queries and noise
		for (int n = 0; n < 900; n++) begin
			r = $urandom_range(0, 99);
			k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 20);
			if (r < 50) begin
				if ($urandom_range(0, 9) == 0) p = PARENT_ROOT;
				else if ($urandom_range(0, 19) == 0) p = $urandom_range(0, 2047);
				else p = pick_vertex();
				send_item(CMD_INSERT, $urandom_range(0, NV - 1), p, k, $urandom_range(0, NV - 1));
			end else if (r < 75) begin
				send_item(CMD_LEVEL_ANC, pick_vertex(), $urandom_range(0, 2047), k,
					$urandom_range(0, NV - 1));
			end else begin
				send_item(CMD_LCA, pick_vertex(), $urandom_range(0, 2047), k, pick_vertex());
			end
			idle_gap();
		end
		start <= 0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
